// File: sv/unicycle_arc_path_predictor_macros.svh
// Assertion macros for the unicycle arc path predictor.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef UNICYCLE_ARC_PATH_PREDICTOR_MACROS_SVH
`define UNICYCLE_ARC_PATH_PREDICTOR_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define UAPP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define UAPP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/uapp_pkg.sv
// Shared types, constants and lookup functions for the unicycle arc path predictor.
// No dependencies; every other file but the assertion macros header imports this package.
`timescale 1ns / 1ps
package uapp_pkg;

  localparam int MAX_STEPS_DEF   = 64;
  localparam int CORDIC_ITER_DEF = 16;

  localparam int AW    = 33;  // angle, Q4.28
  localparam int TW    = 34;  // sine and cosine, Q2.30
  localparam int ZW    = 24;  // residual angle after the rotation steps
  localparam int NUMW  = 51;  // chord numerator
  localparam int DIV_NW = 48; // divider dividend and quotient
  localparam int DIV_DW = 26; // divider divisor
  localparam int CNTW  = 7;   // step count register
  localparam int Q_DEPTH = 2;

  localparam logic signed [AW-1:0] PI_Q28      = 33'sd843314857;
  localparam logic signed [AW-1:0] HALF_PI_Q28 = 33'sd421657428;
  localparam logic signed [AW-1:0] TWO_PI_Q28  = 33'sd1686629713;
  localparam logic signed [TW-1:0] GAIN_Q30    = 34'sd652032874;
  localparam logic signed [TW-1:0] ONE_Q30     = 34'sd1073741824;
  localparam logic signed [31:0]   RAD_TO_BIN_Q44 = 32'sd683565276;

  typedef enum logic [1:0] {
    CFG_STEP_TIME  = 2'd0,
    CFG_STEP_COUNT = 2'd1,
    CFG_THRESHOLD  = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [15:0] heading;
    logic signed [31:0] chord_fwd;
    logic signed [31:0] chord_lat;
    logic signed [15:0] turn_step;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [1:0] {CR_IDLE, CR_ITER, CR_MUL, CR_FIN} cordic_state_t;

  typedef enum logic [3:0] {
    F_IDLE, F_MUL, F_WRAP, F_CSTART, F_CWAIT, F_NUM,
    F_DFS, F_DFW, F_DLS, F_DLW, F_PUSH
  } front_state_t;

  typedef enum logic [3:0] {
    B_IDLE, B_ANG, B_CSTART, B_CWAIT, B_M0, B_M1, B_M2, B_M3,
    B_D1, B_D2, B_EMIT
  } back_state_t;

  // atan(2^-i) in Q4.28, rounded
  function automatic logic signed [AW-1:0] atan_q28(input logic [4:0] i);
    logic [AW-1:0] pw;
    pw = AW'(1) << (5'd28 - i);
    case (i)
      5'd0: atan_q28 = 33'sd210828714;
      5'd1: atan_q28 = 33'sd124459457;
      5'd2: atan_q28 = 33'sd65760959;
      5'd3: atan_q28 = 33'sd33381290;
      5'd4: atan_q28 = 33'sd16755422;
      5'd5: atan_q28 = 33'sd8385879;
      5'd6: atan_q28 = 33'sd4193963;
      5'd7: atan_q28 = 33'sd2097109;
      5'd8: atan_q28 = 33'sd1048571;
      5'd9: atan_q28 = 33'sd524287;
      default: atan_q28 = (i > 5'd28) ? '0 : $signed(pw);
    endcase
  endfunction

  // Signed, saturated result from an unsigned quotient and a sign.
  function automatic logic signed [31:0] sat_quo(input logic [DIV_NW-1:0] q, input logic neg);
    if (!neg) begin
      sat_quo = (q > DIV_NW'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : $signed(q[31:0]);
    end else begin
      sat_quo = (q > DIV_NW'(32'h8000_0000)) ? 32'sh8000_0000 : $signed(-q[31:0]);
    end
  endfunction

  // Q2.30 to Q1.15, rounded and saturated.
  function automatic logic signed [15:0] q30_to_q15(input logic signed [TW-1:0] v);
    logic signed [TW-1:0] r;
    r = (v + TW'(16384)) >>> 15;
    if (r > TW'(32767)) q30_to_q15 = 16'sh7FFF;
    else if (r < -TW'(32768)) q30_to_q15 = 16'sh8000;
    else q30_to_q15 = 16'(r);
  endfunction

endpackage

// File: sv/uapp_cordic.sv
// Iterative rotation-mode CORDIC: sine and cosine in Q2.30 of a Q4.28 angle.
// One rotation per cycle, then a residual-angle correction; uses uapp_pkg.
`timescale 1ns / 1ps
module uapp_cordic import uapp_pkg::*; #(
  parameter int ITER = CORDIC_ITER_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic signed [AW-1:0] angle,
  output logic                 done,
  output logic signed [TW-1:0] sin_o,
  output logic signed [TW-1:0] cos_o
);

  localparam int IW = $clog2(ITER);
  localparam int PW = TW + ZW;
  localparam logic signed [PW-1:0] RND28 = PW'(1) <<< 27;

  cordic_state_t state_r, state_nxt;
  logic [IW-1:0] iter_r;
  logic signed [TW-1:0] x_r, y_r, sin_r, cos_r;
  logic signed [AW-1:0] z_r;
  logic flip_r, done_r;
  logic signed [PW-1:0] pyz_r, pxz_r;
  logic signed [AW-1:0] folded, atan_v;
  logic fold;
  logic signed [ZW-1:0] z_res;
  logic signed [PW-1:0] ryz, rxz;
  logic signed [TW-1:0] nx, ny;

  // fold into [-pi/2, pi/2], flip the result back at the end
  always_comb begin
    fold = 1'b0;
    folded = angle;
    if (angle > HALF_PI_Q28) begin
      folded = angle - PI_Q28;
      fold = 1'b1;
    end else if (angle < -HALF_PI_Q28) begin
      folded = angle + PI_Q28;
      fold = 1'b1;
    end
  end

  assign atan_v = atan_q28(5'(iter_r));
  assign z_res  = ZW'(z_r);
  assign ryz    = (pyz_r + RND28) >>> 28;
  assign rxz    = (pxz_r + RND28) >>> 28;
  assign nx     = x_r - TW'(ryz);
  assign ny     = y_r + TW'(rxz);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      CR_IDLE: if (start) state_nxt = CR_ITER;
      CR_ITER: if (iter_r == IW'(ITER - 1)) state_nxt = CR_MUL;
      CR_MUL:  state_nxt = CR_FIN;
      CR_FIN:  state_nxt = CR_IDLE;
      default: state_nxt = CR_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CR_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= (state_r == CR_FIN);
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      CR_IDLE: if (start) begin
        x_r    <= GAIN_Q30;
        y_r    <= '0;
        z_r    <= folded;
        flip_r <= fold;
        iter_r <= '0;
      end
      CR_ITER: begin
        if (!z_r[AW-1]) begin
          x_r <= x_r - (y_r >>> iter_r);
          y_r <= y_r + (x_r >>> iter_r);
          z_r <= z_r - atan_v;
        end else begin
          x_r <= x_r + (y_r >>> iter_r);
          y_r <= y_r - (x_r >>> iter_r);
          z_r <= z_r + atan_v;
        end
        iter_r <= iter_r + 1'b1;
      end
      CR_MUL: begin
        pyz_r <= y_r * z_res;
        pxz_r <= x_r * z_res;
      end
      CR_FIN: begin
        cos_r <= flip_r ? -nx : nx;
        sin_r <= flip_r ? -ny : ny;
      end
      default: ;
    endcase
  end

  assign done  = done_r;
  assign sin_o = sin_r;
  assign cos_o = cos_r;

endmodule

// File: sv/uapp_div.sv
// Unsigned restoring divider, one quotient bit per cycle.
// Used by the front end for the arc chords; uses uapp_pkg widths.
`timescale 1ns / 1ps
module uapp_div import uapp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DIV_NW-1:0] num,
  input  logic [DIV_DW-1:0] den,
  output logic              done,
  output logic [DIV_NW-1:0] quo
);

  localparam int CW = $clog2(DIV_NW + 1);

  logic [DIV_DW-1:0] rem_r, den_r;
  logic [DIV_NW-1:0] quo_r;
  logic [CW-1:0] cnt_r;
  logic busy_r, done_r;
  logic [DIV_DW:0] shifted;
  logic [DIV_DW+1:0] diff;
  logic borrow;

  assign shifted = {rem_r, quo_r[DIV_NW-1]};
  assign diff    = {1'b0, shifted} - {2'b00, den_r};
  assign borrow  = diff[DIV_DW+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(DIV_NW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      rem_r <= '0;
      den_r <= den;
      quo_r <= num;
    end else if (busy_r) begin
      rem_r <= borrow ? shifted[DIV_DW-1:0] : diff[DIV_DW-1:0];
      quo_r <= {quo_r[DIV_NW-2:0], ~borrow};
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

// File: sv/uapp_front.sv
// Request front end: takes a start pose and twist, classifies straight or arc,
// and works out the per-step chord and turn. Uses uapp_pkg, uapp_cordic, uapp_div.
`timescale 1ns / 1ps
module uapp_front import uapp_pkg::*; #(
  parameter int CORDIC_ITERATIONS = CORDIC_ITER_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_start_x,
  input  logic signed [31:0] in_start_y,
  input  logic signed [15:0] in_start_heading,
  input  logic signed [15:0] in_linear_speed,
  input  logic signed [15:0] in_turn_rate,
  input  logic [15:0]        step_time,
  input  logic [14:0]        straight_threshold,
  output logic               q_push,
  output job_t               q_job,
  input  q_stat_t            q_stat
);

  front_state_t state_r, state_nxt;

  logic signed [31:0] x_r, y_r, cf_r, cl_r;
  logic signed [15:0] h_r, v_r, w_r, tps_r;
  logic signed [AW-1:0] p_r;
  logic signed [32:0] sc_r;
  logic st_r;
  logic signed [TW-1:0] s_r, c_r;
  logic signed [64:0] tprod_r;
  logic signed [NUMW-1:0] nf_r, nl_r;

  logic [15:0] aw;
  logic [DIV_DW-1:0] den;
  logic [DIV_DW-2:0] half;
  logic signed [NUMW-1:0] nf_mag, nl_mag;
  logic [DIV_NW-1:0] div_num, div_quo;
  logic div_start, div_done;
  logic cor_start, cor_done;
  logic signed [TW-1:0] cor_sin, cor_cos;
  logic signed [64:0] tsum;
  logic signed [32:0] sc_rnd;
  logic signed [TW:0] one_minus_c;

  assign aw   = w_r[15] ? 16'(-w_r) : 16'(w_r);
  assign den  = {aw, 10'b0};
  assign half = {aw, 9'b0};
  assign nf_mag = nf_r[NUMW-1] ? -nf_r : nf_r;
  assign nl_mag = nl_r[NUMW-1] ? -nl_r : nl_r;
  assign div_num = ((state_r == F_DFS) ? nf_mag[DIV_NW-1:0] : nl_mag[DIV_NW-1:0])
                   + DIV_NW'(half);
  assign div_start = (state_r == F_DFS) || (state_r == F_DLS);
  assign cor_start = (state_r == F_CSTART);
  assign tsum   = tprod_r + (65'sd1 <<< 43);
  assign sc_rnd = (sc_r + 33'sd128) >>> 8;
  assign one_minus_c = (TW+1)'(ONE_Q30) - (TW+1)'(c_r);

  uapp_cordic #(.ITER(CORDIC_ITERATIONS)) u_cordic (
    .clk(clk), .rst_n(rst_n), .start(cor_start), .angle(p_r),
    .done(cor_done), .sin_o(cor_sin), .cos_o(cor_cos)
  );

  uapp_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num), .den(den),
    .done(div_done), .quo(div_quo)
  );

  assign in_ready = (state_r == F_IDLE);
  assign q_push   = (state_r == F_PUSH) && !q_stat.full;
  assign q_job    = '{x: x_r, y: y_r, heading: h_r, chord_fwd: cf_r,
                      chord_lat: cl_r, turn_step: tps_r};

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      F_IDLE:   if (in_valid) state_nxt = F_MUL;
      F_MUL:    state_nxt = F_WRAP;
      F_WRAP:   state_nxt = st_r ? F_PUSH : F_CSTART;
      F_CSTART: state_nxt = F_CWAIT;
      F_CWAIT:  if (cor_done) state_nxt = F_NUM;
      F_NUM:    state_nxt = F_DFS;
      F_DFS:    state_nxt = F_DFW;
      F_DFW:    if (div_done) state_nxt = F_DLS;
      F_DLS:    state_nxt = F_DLW;
      F_DLW:    if (div_done) state_nxt = F_PUSH;
      F_PUSH:   if (!q_stat.full) state_nxt = F_IDLE;
      default:  state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      F_IDLE: if (in_valid) begin
        x_r <= in_start_x;
        y_r <= in_start_y;
        h_r <= in_start_heading;
        v_r <= in_linear_speed;
        w_r <= in_turn_rate;
      end
      F_MUL: begin
        p_r  <= w_r * $signed({1'b0, step_time});
        sc_r <= v_r * $signed({1'b0, step_time});
        st_r <= (w_r == '0) || (aw < {1'b0, straight_threshold});
      end
      F_WRAP: begin
        if (p_r > PI_Q28) p_r <= p_r - TWO_PI_Q28;
        else if (p_r < -PI_Q28) p_r <= p_r + TWO_PI_Q28;
        if (st_r) begin
          cf_r  <= 32'(sc_rnd);
          cl_r  <= '0;
          tps_r <= '0;
        end
      end
      F_CWAIT: begin
        tprod_r <= p_r * RAD_TO_BIN_Q44;
        if (cor_done) begin
          s_r <= cor_sin;
          c_r <= cor_cos;
        end
      end
      F_NUM: begin
        nf_r  <= v_r * s_r;
        nl_r  <= v_r * one_minus_c;
        tps_r <= tsum[59:44];
      end
      F_DFW: if (div_done) cf_r <= sat_quo(div_quo, nf_r[NUMW-1] ^ w_r[15]);
      F_DLW: if (div_done) cl_r <= sat_quo(div_quo, nl_r[NUMW-1] ^ w_r[15]);
      default: ;
    endcase
  end

endmodule

// File: sv/uapp_queue.sv
// Two-entry job queue between the front end and the pose stepper.
// Holds job_t entries from uapp_pkg.
`timescale 1ns / 1ps
module uapp_queue import uapp_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  job_t    job_i,
  input  logic    pop,
  output job_t    job_o,
  output q_stat_t stat
);

  localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CW = $clog2(Q_DEPTH + 1);

  job_t entry_r [Q_DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r;

  assign stat.full  = (cnt_r == CW'(Q_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign job_o = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == PW'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= (rd_ptr_r == PW'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      if (push && !pop) cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) entry_r[wr_ptr_r] <= job_i;
  end

endmodule

// File: sv/uapp_back.sv
// Pose stepper: rotates each chord by the heading, accumulates position, advances
// the heading and emits one pose per step. Uses uapp_pkg and two uapp_cordic units.
`timescale 1ns / 1ps
module uapp_back import uapp_pkg::*; #(
  parameter int MAX_STEPS         = MAX_STEPS_DEF,
  parameter int CORDIC_ITERATIONS = CORDIC_ITER_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  job_t               q_job,
  input  q_stat_t            q_stat,
  output logic               q_pop,
  input  logic [CNTW-1:0]    step_count,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_pose_x,
  output logic signed [31:0] out_pose_y,
  output logic signed [15:0] out_pose_heading,
  output logic signed [15:0] out_quat_z,
  output logic signed [15:0] out_quat_w,
  output logic [5:0]         out_step_index,
  output logic               out_last_step
);

  localparam int KW = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
  localparam int PW = TW + 32;

  back_state_t state_r, state_nxt;

  logic signed [31:0] acc_x_r, acc_y_r, cf_r, cl_r;
  logic signed [15:0] head_r, hn_r, tps_r, qz_r, qw_r;
  logic [KW-1:0] k_r;
  logic signed [47:0] a1_r, a2_r;
  logic signed [TW-1:0] sh_r, ch_r, sq_r, cq_r;
  logic signed [PW-1:0] p0_r, p1_r, p2_r, p3_r;
  logic signed [36:0] dx_r, dy_r;
  logic out_valid_r, out_last_r;
  logic signed [31:0] ox_r, oy_r;
  logic signed [15:0] oh_r, oz_r, ow_r;
  logic [5:0] oi_r;

  logic [CNTW-1:0] count_eff;
  logic is_last, emit;
  logic signed [AW-1:0] ang1, ang2;
  logic c1_done, c2_done;
  logic signed [TW-1:0] c1_sin, c1_cos, c2_sin, c2_cos;
  logic signed [TW-1:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [PW-1:0] prod;
  logic signed [PW:0] ex, ey;
  logic signed [37:0] sx, sy;

  assign count_eff = (step_count > CNTW'(MAX_STEPS)) ? CNTW'(MAX_STEPS) : step_count;
  assign is_last   = (CNTW'(k_r) + 1'b1 == count_eff);
  assign emit      = (state_r == B_EMIT) && (!out_valid_r || out_ready);
  assign q_pop     = (state_r == B_IDLE) && !q_stat.empty;

  assign ang1 = AW'((a1_r + 48'sd32768) >>> 16);
  assign ang2 = AW'((a2_r + 48'sd65536) >>> 17);

  uapp_cordic #(.ITER(CORDIC_ITERATIONS)) u_cordic_move (
    .clk(clk), .rst_n(rst_n), .start(state_r == B_CSTART), .angle(ang1),
    .done(c1_done), .sin_o(c1_sin), .cos_o(c1_cos)
  );

  uapp_cordic #(.ITER(CORDIC_ITERATIONS)) u_cordic_half (
    .clk(clk), .rst_n(rst_n), .start(state_r == B_CSTART), .angle(ang2),
    .done(c2_done), .sin_o(c2_sin), .cos_o(c2_cos)
  );

  // one shared multiplier walks the four rotation products
  always_comb begin
    case (state_r)
      B_M0:    begin mul_a = ch_r; mul_b = cf_r; end
      B_M1:    begin mul_a = sh_r; mul_b = cl_r; end
      B_M2:    begin mul_a = sh_r; mul_b = cf_r; end
      default: begin mul_a = ch_r; mul_b = cl_r; end
    endcase
  end
  assign prod = mul_a * mul_b;

  assign ex = (PW+1)'(p0_r) - (PW+1)'(p1_r) + ((PW+1)'(1) <<< 29);
  assign ey = (PW+1)'(p2_r) + (PW+1)'(p3_r) + ((PW+1)'(1) <<< 29);
  assign sx = 38'(acc_x_r) + 38'(dx_r);
  assign sy = 38'(acc_y_r) + 38'(dy_r);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE:   if (!q_stat.empty && count_eff != '0) state_nxt = B_ANG;
      B_ANG:    state_nxt = B_CSTART;
      B_CSTART: state_nxt = B_CWAIT;
      B_CWAIT:  if (c1_done && c2_done) state_nxt = B_M0;
      B_M0:     state_nxt = B_M1;
      B_M1:     state_nxt = B_M2;
      B_M2:     state_nxt = B_M3;
      B_M3:     state_nxt = B_D1;
      B_D1:     state_nxt = B_D2;
      B_D2:     state_nxt = B_EMIT;
      B_EMIT:   if (emit) state_nxt = is_last ? B_IDLE : B_ANG;
      default:  state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (emit) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      B_IDLE: if (q_pop) begin
        acc_x_r <= q_job.x;
        acc_y_r <= q_job.y;
        head_r  <= q_job.heading;
        cf_r    <= q_job.chord_fwd;
        cl_r    <= q_job.chord_lat;
        tps_r   <= q_job.turn_step;
        k_r     <= '0;
      end
      B_ANG: begin
        hn_r <= head_r + tps_r;
        a1_r <= head_r * TWO_PI_Q28;
        // wrap the advanced heading before scaling it
        a2_r <= 16'(head_r + tps_r) * TWO_PI_Q28;
      end
      B_CWAIT: if (c1_done && c2_done) begin
        sh_r <= c1_sin;
        ch_r <= c1_cos;
        sq_r <= c2_sin;
        cq_r <= c2_cos;
      end
      B_M0: p0_r <= prod;
      B_M1: p1_r <= prod;
      B_M2: p2_r <= prod;
      B_M3: p3_r <= prod;
      B_D1: begin
        dx_r <= 37'(ex >>> 30);
        dy_r <= 37'(ey >>> 30);
      end
      B_D2: begin
        // saturate the position at the int32 limits
        if (sx > 38'sh7FFF_FFFF) acc_x_r <= 32'sh7FFF_FFFF;
        else if (sx < -38'sh8000_0000) acc_x_r <= 32'sh8000_0000;
        else acc_x_r <= 32'(sx);
        if (sy > 38'sh7FFF_FFFF) acc_y_r <= 32'sh7FFF_FFFF;
        else if (sy < -38'sh8000_0000) acc_y_r <= 32'sh8000_0000;
        else acc_y_r <= 32'(sy);
        head_r <= hn_r;
        qz_r   <= q30_to_q15(sq_r);
        qw_r   <= q30_to_q15(cq_r);
      end
      B_EMIT: if (emit) begin
        ox_r       <= acc_x_r;
        oy_r       <= acc_y_r;
        oh_r       <= head_r;
        oz_r       <= qz_r;
        ow_r       <= qw_r;
        oi_r       <= 6'(k_r);
        out_last_r <= is_last;
        k_r        <= k_r + 1'b1;
      end
      default: ;
    endcase
  end

  assign out_valid        = out_valid_r;
  assign out_pose_x       = ox_r;
  assign out_pose_y       = oy_r;
  assign out_pose_heading = oh_r;
  assign out_quat_z       = oz_r;
  assign out_quat_w       = ow_r;
  assign out_step_index   = oi_r;
  assign out_last_step    = out_last_r;

endmodule

// File: sv/unicycle_arc_path_predictor.sv
// Front end: the divider runs twice for an arc request and not at all for a
// straight one. Pose stepper: both CORDIC units run once for every pose.
// Reset (synchronous, active low) empties the queue, idles both sides and loads
// the register defaults.
`timescale 1ns / 1ps
module unicycle_arc_path_predictor import uapp_pkg::*; #(
  parameter int MAX_STEPS         = MAX_STEPS_DEF,
  parameter int CORDIC_ITERATIONS = CORDIC_ITER_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_start_x,
  input  logic signed [31:0] in_start_y,
  input  logic signed [15:0] in_start_heading,
  input  logic signed [15:0] in_linear_speed,
  input  logic signed [15:0] in_turn_rate,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_pose_x,
  output logic signed [31:0] out_pose_y,
  output logic signed [15:0] out_pose_heading,
  output logic signed [15:0] out_quat_z,
  output logic signed [15:0] out_quat_w,
  output logic [5:0]         out_step_index,
  output logic               out_last_step
);

`include "unicycle_arc_path_predictor_macros.svh"

  logic [15:0] step_time_r;
  logic [CNTW-1:0] step_count_r;
  logic [14:0] threshold_r;

  logic q_push, q_pop;
  job_t q_job_in, q_job_out;
  q_stat_t q_stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_time_r  <= 16'd3277;
      step_count_r <= CNTW'(60);
      threshold_r  <= 15'd4;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_STEP_TIME:  step_time_r  <= cfg_wdata;
        CFG_STEP_COUNT: step_count_r <= cfg_wdata[CNTW-1:0];
        CFG_THRESHOLD:  threshold_r  <= cfg_wdata[14:0];
        default: ;
      endcase
    end
  end

  uapp_front #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_start_x(in_start_x), .in_start_y(in_start_y),
    .in_start_heading(in_start_heading), .in_linear_speed(in_linear_speed),
    .in_turn_rate(in_turn_rate),
    .step_time(step_time_r), .straight_threshold(threshold_r),
    .q_push(q_push), .q_job(q_job_in), .q_stat(q_stat)
  );

  uapp_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(q_push), .job_i(q_job_in),
    .pop(q_pop), .job_o(q_job_out), .stat(q_stat)
  );

  uapp_back #(.MAX_STEPS(MAX_STEPS), .CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_back (
    .clk(clk), .rst_n(rst_n),
    .q_job(q_job_out), .q_stat(q_stat), .q_pop(q_pop),
    .step_count(step_count_r),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_pose_x(out_pose_x), .out_pose_y(out_pose_y),
    .out_pose_heading(out_pose_heading),
    .out_quat_z(out_quat_z), .out_quat_w(out_quat_w),
    .out_step_index(out_step_index), .out_last_step(out_last_step)
  );

  `UAPP_ASSERT_NOW(a_no_push_full, q_push, !q_stat.full, "job pushed into a full queue")
  `UAPP_ASSERT_NOW(a_no_pop_empty, q_pop, !q_stat.empty, "job popped from an empty queue")
  `UAPP_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "front took a second request")

endmodule

// File: bench/tb_unicycle_arc_path_predictor.sv
// Self-checking bench for unicycle_arc_path_predictor: drives pose requests and
// compares every predicted pose with an in-bench fixed-point path model.
// Depends on uapp_pkg and the top-level RTL.
`timescale 1ns / 1ps
module tb_unicycle_arc_path_predictor import uapp_pkg::*;;

  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [15:0] hd;
    logic signed [15:0] qz;
    logic signed [15:0] qw;
    logic [5:0]         idx;
    logic               last;
  } pose_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [15:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] in_start_x = '0, in_start_y = '0;
  logic signed [15:0] in_start_heading = '0, in_linear_speed = '0, in_turn_rate = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] out_pose_x, out_pose_y;
  logic signed [15:0] out_pose_heading, out_quat_z, out_quat_w;
  logic [5:0] out_step_index;
  logic out_last_step;

  unicycle_arc_path_predictor u_top (.*);

  // register shadows
  longint dt_q16 = 3277;
  longint pose_count = 60;
  longint straight_thr = 4;

  pose_t expected_poses[$];
  int mismatches = 0;
  int poses_seen = 0;
  int requests_sent = 0;
  int idle_cycles = 0;

  initial forever #2 clk = ~clk;

  function automatic longint asr64(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint round_up(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint clamp32(longint v);
    if (v < -64'sd2147483648) return -64'sd2147483648;
    if (v > 64'sd2147483647) return 64'sd2147483647;
    return v;
  endfunction

  function automatic longint wrap_bin(longint v);
    logic signed [15:0] t;
    t = v[15:0];
    return longint'(t);
  endfunction

  function automatic longint div_nearest(longint n, longint d);
    bit neg;
    longint un, ud, q;
    neg = (n < 0) != (d < 0);
    un = n < 0 ? -n : n;
    ud = d < 0 ? -d : d;
    q = (un + ud / 2) / ud;
    return neg ? -q : q;
  endfunction

  function automatic longint arctan_step(int i);
    longint sum, t;
    int e;
    sum = 0;
    if (i == 0) return 64'sd210828714;
    for (int k = 0; k < 64; k++) begin
      e = i * (2 * k + 1);
      if (e > 60) break;
      t = longint'((64'd1 << (60 - e)) / (2 * k + 1));
      sum += (k % 2) ? -t : t;
    end
    return round_up(sum, 32);
  endfunction

  // sine and cosine in Q2.30 of a Q4.28 angle
  task automatic rotate_unit(input longint ang, output longint s, output longint c);
    bit flip;
    longint x, y, z, nx, ny, t;
    flip = 0;
    x = 64'sd652032874;
    y = 0;
    if (ang > 64'sd421657428) begin ang -= 64'sd843314857; flip = 1; end
    else if (ang < -64'sd421657428) begin ang += 64'sd843314857; flip = 1; end
    z = ang;
    for (int i = 0; i < CORDIC_ITER_DEF; i++) begin
      t = arctan_step(i);
      if (z >= 0) begin
        nx = x - asr64(y, i); ny = y + asr64(x, i); z -= t;
      end else begin
        nx = x + asr64(y, i); ny = y - asr64(x, i); z += t;
      end
      x = nx; y = ny;
    end
    nx = x - round_up(y * z, 28);
    ny = y + round_up(x * z, 28);
    c = flip ? -nx : nx;
    s = flip ? -ny : ny;
  endtask

  function automatic longint to_q15(longint v);
    longint r;
    r = round_up(v, 15);
    if (r > 32767) return 32767;
    if (r < -32768) return -32768;
    return r;
  endfunction

  task automatic predict_path(input logic signed [31:0] sx, input logic signed [31:0] sy,
                              input logic signed [15:0] sh, input logic signed [15:0] spd,
                              input logic signed [15:0] rate);
    longint v, w, aw, px, py, hd, fwd, lat, turn, p, s, c, shn, chn, sq, cq;
    int n;
    pose_t e;
    v = spd; w = rate;
    aw = w < 0 ? -w : w;
    n = pose_count > MAX_STEPS_DEF ? MAX_STEPS_DEF : int'(pose_count);
    px = sx; py = sy; hd = sh;
    if (w == 0 || aw < straight_thr) begin
      fwd = clamp32(round_up(v * dt_q16, 8));
      lat = 0;
      turn = 0;
    end else begin
      p = w * dt_q16;
      while (p > 64'sd843314857) p -= 64'sd1686629713;
      while (p < -64'sd843314857) p += 64'sd1686629713;
      rotate_unit(p, s, c);
      fwd = clamp32(div_nearest(v * s, w * 1024));
      lat = clamp32(div_nearest(v * (64'sd1073741824 - c), w * 1024));
      turn = wrap_bin(round_up(p * 64'sd683565276, 44));
    end
    for (int k = 0; k < n; k++) begin
      rotate_unit(round_up(hd * 64'sd1686629713, 16), shn, chn);
      px = clamp32(px + round_up(chn * fwd - shn * lat, 30));
      py = clamp32(py + round_up(shn * fwd + chn * lat, 30));
      hd = wrap_bin(hd + turn);
      rotate_unit(round_up(hd * 64'sd1686629713, 17), sq, cq);
      e.x = px[31:0]; e.y = py[31:0]; e.hd = hd[15:0];
      e.qz = to_q15(sq); e.qw = to_q15(cq);
      e.idx = k[5:0]; e.last = (k + 1 == n);
      expected_poses.insert(expected_poses.size(), e);
    end
  endtask

  // one beat on the request channel; valid stays up into a zero-gap follow-on
  task automatic send_request(input logic signed [31:0] sx, input logic signed [31:0] sy,
                              input logic signed [15:0] sh, input logic signed [15:0] spd,
                              input logic signed [15:0] rate);
    int gap;
    gap = $urandom_range(0, 4);
    if ($urandom_range(0, 3) == 0) gap = 0;
    predict_path(sx, sy, sh, spd, rate);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_start_x <= sx; in_start_y <= sy; in_start_heading <= sh;
    in_linear_speed <= spd; in_turn_rate <= rate;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    requests_sent++;
  endtask

  task automatic drain_and_settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_poses.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_STEP_TIME: dt_q16 = val;
      CFG_STEP_COUNT: pose_count = val[6:0];
      default: straight_thr = val[14:0];
    endcase
  endtask

  task automatic set_regs(input logic [15:0] dt, input logic [15:0] cnt, input logic [15:0] thr);
    drain_and_settle();
    write_reg(CFG_STEP_TIME, dt);
    write_reg(CFG_STEP_COUNT, cnt);
    write_reg(CFG_THRESHOLD, thr);
  endtask

  task automatic test_field_extremes();
    set_regs(16'd3277, 16'd4, 16'd4);
    send_request(32'sh7FFF_FFF0, 32'sh8000_0010, 16'sh7FFF, 16'sh7FFF, 16'sd0);
    send_request(32'sh8000_0000, 32'sh7FFF_FFFF, 16'sh8000, 16'sh8000, 16'sh7FFF);
    send_request(32'sd0, 32'sd0, 16'sd0, 16'sh7FFF, 16'sh8000);
    send_request(-32'sd1, 32'sd1, 16'sh4000, 16'sd256, 16'sd3);
    send_request(32'sd65536, -32'sd65536, -16'sh4000, -16'sd256, 16'sd4);
  endtask

  task automatic test_special_cases();
    // zero step time holds the start pose
    set_regs(16'd0, 16'd3, 16'd0);
    send_request(32'sd12345, -32'sd999, 16'sd1000, 16'sd512, 16'sd4096);
    // zero turn rate with zero threshold still goes straight
    send_request(32'sd0, 32'sd0, 16'sd0, 16'sd512, 16'sd0);
    // count above the cap, then zero count
    set_regs(16'hFFFF, 16'd127, 16'd32767);
    send_request(32'sd0, 32'sd0, 16'sh2000, 16'sh7FFF, 16'sh7FFF);
    set_regs(16'hFFFF, 16'd0, 16'd0);
    send_request(32'sd5, 32'sd6, 16'sd7, 16'sd8, 16'sd9);
    // turn of about pi per step
    set_regs(16'd32768, 16'd5, 16'd1);
    send_request(32'sd0, 32'sd0, 16'sd0, 16'sd256, 16'sd25736);
    send_request(32'sd0, 32'sd0, 16'sh8000, -16'sd256, -16'sd25736);
    set_regs(16'd1, 16'd64, 16'd0);
    send_request(32'sd0, 32'sd0, 16'sd0, 16'sd256, -16'sd1);
  endtask

  task automatic test_random_requests();
    logic signed [15:0] rate;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: set_regs(16'd3277, 16'd6, 16'd4);
        1: set_regs(16'($urandom), 16'($urandom_range(1, 8)), 16'($urandom_range(0, 2000)));
        2: set_regs(16'd65535, 16'd3, 16'd32767);
        default: set_regs(16'($urandom_range(1, 8000)), 16'd1, 16'd0);
      endcase
      for (int i = 0; i < 48; i++) begin
        case ($urandom_range(0, 3))
          0: rate = 16'sd0;
          1: rate = 16'($urandom_range(0, 64)) - 16'sd32;
          default: rate = 16'($urandom);
        endcase
        send_request(32'($urandom), 32'($urandom), 16'($urandom), 16'($urandom), rate);
      end
    end
  endtask

  // result side: random stalls, compare each beat with the oldest prediction
  initial begin
    pose_t e;
    int stall;
    stall = 0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
      end
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        poses_seen++;
        stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
        if (expected_poses.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected pose beat x=%0d", out_pose_x);
        end else begin
          e = expected_poses.pop_front();
          if (out_pose_x !== e.x || out_pose_y !== e.y || out_pose_heading !== e.hd ||
              out_quat_z !== e.qz || out_quat_w !== e.qw ||
              out_step_index !== e.idx || out_last_step !== e.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("pose mismatch exp x=%0d y=%0d h=%0d z=%0d w=%0d i=%0d l=%0d | got x=%0d y=%0d h=%0d z=%0d w=%0d i=%0d l=%0d",
                e.x, e.y, e.hd, e.qz, e.qw, e.idx, e.last, out_pose_x, out_pose_y,
                out_pose_heading, out_quat_z, out_quat_w, out_step_index, out_last_step);
          end
        end
      end
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d poses pending", expected_poses.size());
      $display("tb_unicycle_arc_path_predictor: done, errors");
      $finish;
    end
  end

  initial begin
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    test_field_extremes();
    test_special_cases();
    test_random_requests();
    drain_and_settle();
    if (expected_poses.size() != 0) mismatches++;
    $display("covered %0d requests and %0d poses over straight, arc and edge settings",
      requests_sent, poses_seen);
    if (mismatches == 0) begin
      $display("tb_unicycle_arc_path_predictor: done, clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("tb_unicycle_arc_path_predictor: done, errors");
    end
    $finish;
  end
endmodule
